[hw/rtl/wsvfe_pkg.sv]
// Package for the WebSocket video frame encapsulator.
// Holds request/result structs and protocol constants; no dependencies.
`default_nettype none
package wsvfe_pkg;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    localparam logic [31:0] MAGIC_WORD = 32'h342E_5452;
    localparam logic [31:0] H264_KEY   = 32'h344B_0000;
    localparam logic [31:0] H264_DLT   = 32'h3450_0000;
    localparam logic [31:0] H265_KEY   = 32'h354B_0000;
    localparam logic [31:0] H265_DLT   = 32'h3550_0000;

    localparam int TLV_BYTES      = 16;
    localparam int HDR_BYTES_MAX  = 14;
    localparam int FRAME_BYTES_MAX = HDR_BYTES_MAX + TLV_BYTES;

    localparam logic [7:0]  WS_BINARY_FIN = 8'h82;
    localparam logic [6:0]  LEN_CODE16    = 7'd126;
    localparam logic [6:0]  LEN_CODE64    = 7'd127;
    localparam logic [32:0] LEN7_LIMIT    = 33'd126;
    localparam logic [32:0] LEN16_LIMIT   = 33'd65536;

    typedef struct packed {
        logic        action;
        logic [31:0] payload_length;
        logic        is_delta_frame;
        logic        is_key_frame;
        logic        client_mode;
        logic [31:0] mask_key;
        logic [7:0]  data_byte;
    } in_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_frame;
    } out_res_t;

endpackage
`default_nettype wire

[hw/rtl/websocket_video_frame_encapsulator_top.sv]
// A request is loaded into the shift-out byte buffer, then each byte into m_res.
// Throughput: one payload byte per cycle unless m_ready stalls the output; a frame
// start holds the emitter until its 18 to 30 header/TLV bytes are shifted out.
// Reset (aresetn, synchronous, active low) clears the sequence number, frame
// state, codec select and all valid flags.
// Top level; depends on wsvfe_pkg.
`default_nettype none
module websocket_video_frame_encapsulator_top
    import wsvfe_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_req_t  s_req,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_res_t      m_res,
    input  wire logic     cfg_wr_en,
    input  wire logic     cfg_wr_data
);

    logic        codec_sel_reg;
    logic [31:0] seq_reg;
    logic [31:0] remaining_reg;
    logic        active_reg;
    logic [31:0] held_key_reg;
    logic [1:0]  phase_reg;
    logic        held_client_reg;

    logic                                a_valid_reg;
    logic [FRAME_BYTES_MAX-1:0][7:0]     buf_reg;
    logic [4:0]                          cnt_reg;
    logic                                eof_reg;

    logic     m_valid_reg;
    out_res_t m_res_reg;

    logic out_free, a_emit, a_done, accept, flagged, load;

    logic [31:0] ptype;
    logic [32:0] wlen;
    logic [63:0] w64;
    logic [3:0][7:0] keyb;
    logic [127:0] tlv_word;
    logic [TLV_BYTES-1:0][7:0] tlv;
    logic [HDR_BYTES_MAX-1:0][7:0] hb;
    logic [4:0] hlen;
    logic [4:0] off;
    logic [FRAME_BYTES_MAX-1:0][7:0] buf_new;
    logic [7:0] data_masked;

    assign out_free = !m_valid_reg || m_ready;
    assign a_emit   = a_valid_reg && out_free;
    assign a_done   = a_emit && (cnt_reg == 5'd1);
    assign s_ready  = !a_valid_reg || a_done;
    assign accept   = s_valid && s_ready;
    assign flagged  = s_req.is_delta_frame || s_req.is_key_frame;
    assign load     = accept && ((s_req.action == ACT_DATA) ? active_reg : flagged);

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    always_comb begin
        if (codec_sel_reg) begin
            ptype = s_req.is_delta_frame ? H265_DLT : H265_KEY;
        end else begin
            ptype = s_req.is_delta_frame ? H264_DLT : H264_KEY;
        end
        wlen = {1'b0, s_req.payload_length} + 33'(TLV_BYTES);
        w64  = {31'd0, wlen};
        keyb = {s_req.mask_key[7:0], s_req.mask_key[15:8],
                s_req.mask_key[23:16], s_req.mask_key[31:24]};
        tlv_word = {s_req.payload_length, ptype, seq_reg, MAGIC_WORD};
        if (s_req.client_mode) begin
            tlv_word = tlv_word ^ {4{keyb}};
        end
        tlv = tlv_word;

        hb    = '0;
        hb[0] = WS_BINARY_FIN;
        if (wlen < LEN7_LIMIT) begin
            hb[1] = {s_req.client_mode, wlen[6:0]};
            for (int k = 0; k < 4; k++) begin
                hb[2 + k] = keyb[k];
            end
            hlen = 5'd2;
        end else if (wlen < LEN16_LIMIT) begin
            hb[1] = {s_req.client_mode, LEN_CODE16};
            hb[2] = wlen[15:8];
            hb[3] = wlen[7:0];
            for (int k = 0; k < 4; k++) begin
                hb[4 + k] = keyb[k];
            end
            hlen = 5'd4;
        end else begin
            hb[1] = {s_req.client_mode, LEN_CODE64};
            for (int k = 0; k < 8; k++) begin
                hb[2 + k] = w64[63 - 8 * k -: 8];
            end
            for (int k = 0; k < 4; k++) begin
                hb[10 + k] = keyb[k];
            end
            hlen = 5'd10;
        end
        if (s_req.client_mode) begin
            hlen = hlen + 5'd4;
        end

        buf_new = '0;
        off     = '0;
        for (int i = 0; i < HDR_BYTES_MAX; i++) begin
            off = 5'(i) - hlen;
            if (5'(i) < hlen) begin
                buf_new[i] = hb[i];
            end else begin
                buf_new[i] = tlv[off[3:0]];
            end
        end
        for (int i = HDR_BYTES_MAX; i < FRAME_BYTES_MAX; i++) begin
            off = 5'(i) - hlen;
            if (off < 5'(TLV_BYTES)) begin
                buf_new[i] = tlv[off[3:0]];
            end
        end

        data_masked = s_req.data_byte;
        if (held_client_reg) begin
            data_masked = data_masked ^ held_key_reg[31 - 8 * phase_reg -: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_sel_reg   <= 1'b0;
            seq_reg         <= '0;
            remaining_reg   <= '0;
            active_reg      <= 1'b0;
            held_key_reg    <= '0;
            phase_reg       <= '0;
            held_client_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                codec_sel_reg <= cfg_wr_data;
            end
            if (accept) begin
                if (s_req.action == ACT_DATA) begin
                    if (active_reg) begin
                        phase_reg     <= phase_reg + 2'd1;
                        remaining_reg <= remaining_reg - 32'd1;
                        if (remaining_reg == 32'd1) begin
                            active_reg <= 1'b0;
                        end
                    end
                end else begin
                    active_reg <= flagged && (s_req.payload_length != 32'd0);
                    if (flagged) begin
                        seq_reg         <= seq_reg + 32'd1;
                        held_key_reg    <= s_req.mask_key;
                        held_client_reg <= s_req.client_mode;
                        phase_reg       <= '0;
                        remaining_reg   <= s_req.payload_length;
                    end
                end
            end
        end
    end

    // emitter: shift-out byte buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (load) begin
            a_valid_reg <= 1'b1;
        end else if (a_done) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (s_req.action == ACT_DATA) begin
                buf_reg <= {{(FRAME_BYTES_MAX - 1){8'h00}}, data_masked};
                cnt_reg <= 5'd1;
                eof_reg <= (remaining_reg == 32'd1);
            end else begin
                buf_reg <= buf_new;
                cnt_reg <= hlen + 5'(TLV_BYTES);
                eof_reg <= (s_req.payload_length == 32'd0);
            end
        end else if (a_emit) begin
            buf_reg <= {8'h00, buf_reg[FRAME_BYTES_MAX-1:1]};
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_emit) begin
            m_res_reg.out_byte     <= buf_reg[0];
            m_res_reg.last_of_run  <= (cnt_reg == 5'd1);
            m_res_reg.end_of_frame <= (cnt_reg == 5'd1) && eof_reg;
        end
    end

endmodule
`default_nettype wire
